[hw/rtl/pfm_pkg.sv]
// Package: shared constants, codes and types of the paging frame manager.
package pfm_pkg;

    localparam int FRAME_COUNT       = 256;
    localparam int PAGES_PER_PROCESS = 256;
    localparam int PROCESS_SLOTS     = 8;

    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int VPN_W   = $clog2(PAGES_PER_PROCESS);
    localparam int PID_W   = $clog2(PROCESS_SLOTS);
    localparam int PADDR_W = PID_W + VPN_W;
    localparam int LIMIT_W = 9;
    localparam int AGE_W   = 8;
    localparam int CNT_W   = 32;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_FAULT = 2'd1;
    localparam logic [1:0] ACT_MARK  = 2'd2;
    localparam logic [1:0] ACT_START = 2'd3;

    // status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_RESIDENT = 3'd1;
    localparam logic [2:0] ST_NO_FRAME = 3'd2;
    localparam logic [2:0] ST_NO_TABLE = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic [AGE_W-1:0] AGE_FRESH = 8'h80;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         pid;
        logic [7:0]         vpn;
        logic [7:0]         frame_number;
        logic [8:0]         floor_request;
        logic [8:0]         cap_request;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         frame;
        logic               evicted;
        logic [7:0]         evicted_frame;
        logic [2:0]         evicted_pid;
        logic [7:0]         evicted_vpn;
        logic               writeback;
    } rsp_t;

    typedef struct packed {
        logic [PID_W-1:0]   owner;
        logic [VPN_W-1:0]   page;
        logic [AGE_W-1:0]   age;
        logic [CNT_W-1:0]   count;
    } frame_ent_t;

    typedef struct packed {
        logic               present;
        logic [FRAME_W-1:0] frame;
        logic               dirty;
        logic               referenced;
        logic [AGE_W-1:0]   age;
    } page_ent_t;

    typedef struct packed {
        logic               valid;
        logic [AGE_W-1:0]   age;
        logic [CNT_W-1:0]   count;
    } rank_t;

endpackage

[hw/rtl/pfm_stream_if.sv]
// Interface: valid/ready request channel carrying one payload.
interface pfm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/paging_frame_manager_lfu_aging.sv]
// Top level: demand-paging frame manager with aging replacement.
// Every request is handled by one sequencer that walks the frame table
// (256 entries) and the page tables (8 slots x 256 entries) through
// memories with registered reads and separate write ports, one entry per step,
// using a shared ranking comparator for victim choice. One request is in flight
// at a time; req.ready is high only when the sequencer is idle, and the
// response register lets the next request in while a response waits.
// A write mark reads the frame entry, then the page entry, and writes
// both back; a fault on a resident page ends after its page entry read;
// a fault from a slot at its cap first scans the slot's own page entries
// for a victim and reclaims it, then an allocating fault runs the
// rotating free-frame search, and the global victim scan if no frame is
// free; a first process start clears the slot's 256 page entries (one per
// cycle) after the frame search; an aging tick skips each inactive slot
// and visits every page entry of each active slot. No clearing pass after
// reset: a slot's page table is cleared when the slot first gets a table,
// before any read.
module paging_frame_manager_lfu_aging
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [8:0]                cfg_data,
    pfm_stream_if.sink                req,
    pfm_stream_if.source              rsp
);

    localparam int FW = pfm_pkg::FRAME_W;
    localparam int VW = pfm_pkg::VPN_W;
    localparam int PW = pfm_pkg::PID_W;
    localparam int AW = pfm_pkg::PADDR_W;
    localparam int LW = pfm_pkg::LIMIT_W;
    localparam int NF = pfm_pkg::FRAME_COUNT;
    localparam int NP = pfm_pkg::PAGES_PER_PROCESS;
    localparam int NS = pfm_pkg::PROCESS_SLOTS;
    localparam int IW = $clog2(NF + 1);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_F_CHK  = 5'd2;
    localparam logic [4:0] S_CAP_RD = 5'd3;
    localparam logic [4:0] S_CAP_PG = 5'd4;
    localparam logic [4:0] S_CAP_FR = 5'd5;
    localparam logic [4:0] S_CAP_END = 5'd6;
    localparam logic [4:0] S_RC_RD  = 5'd7;
    localparam logic [4:0] S_RC_FR  = 5'd8;
    localparam logic [4:0] S_RC_PG  = 5'd9;
    localparam logic [4:0] S_RC_FREE = 5'd10;
    localparam logic [4:0] S_TAKE   = 5'd11;
    localparam logic [4:0] S_GV_RD  = 5'd12;
    localparam logic [4:0] S_GV_FR  = 5'd13;
    localparam logic [4:0] S_F_FIN  = 5'd14;
    localparam logic [4:0] S_MK_FR  = 5'd15;
    localparam logic [4:0] S_MK_PG  = 5'd16;
    localparam logic [4:0] S_ST_CLR = 5'd17;
    localparam logic [4:0] S_ST_LIM = 5'd18;
    localparam logic [4:0] S_AG_RD  = 5'd19;
    localparam logic [4:0] S_AG_PG  = 5'd20;
    localparam logic [4:0] S_AG_FR  = 5'd21;
    localparam logic [4:0] S_FIN    = 5'd22;

    // memories
    pfm_pkg::frame_ent_t frame_mem [NF];
    pfm_pkg::page_ent_t  page_mem  [NS*NP];
    pfm_pkg::frame_ent_t fr_rd;
    pfm_pkg::page_ent_t  pg_rd;
    logic [FW-1:0]       fr_raddr, fr_waddr;
    logic [AW-1:0]       pg_raddr, pg_waddr;
    logic                fr_we, pg_we;
    pfm_pkg::frame_ent_t fr_wdata;
    pfm_pkg::page_ent_t  pg_wdata;

    always_ff @(posedge clk)
    begin
        if (fr_we)
            frame_mem[fr_waddr] <= fr_wdata;
        fr_rd <= frame_mem[fr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pg_we)
            page_mem[pg_waddr] <= pg_wdata;
        pg_rd <= page_mem[pg_raddr];
    end

    // control and status registers
    logic [4:0]          state_reg, state_next;
    pfm_pkg::req_t       req_reg, req_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [PW-1:0]       slot_reg, slot_next;
    logic [8:0]          floor_cfg_reg, floor_cfg_next;
    logic [NF-1:0]       used_reg, used_next;
    logic [NF-1:0]       tbl_reg, tbl_next;
    logic [IW-1:0]       free_reg, free_next;
    logic [FW-1:0]       hint_reg, hint_next;
    logic [NS-1:0]       active_reg, active_next;
    logic [NS-1:0]       has_tbl_reg, has_tbl_next;
    logic [LW-1:0]       held_reg [NS];
    logic [LW-1:0]       held_next [NS];
    logic [LW-1:0]       pfloor_reg [NS];
    logic [LW-1:0]       pfloor_next [NS];
    logic [LW-1:0]       cap_reg [NS];
    logic [LW-1:0]       cap_next [NS];
    logic [FW-1:0]       tframe_reg [NS];
    logic [FW-1:0]       tframe_next [NS];
    pfm_pkg::rank_t      best_reg, best_next;
    logic [FW-1:0]       best_f_reg, best_f_next;
    logic [FW-1:0]       cand_reg, cand_next;
    logic [FW-1:0]       new_f_reg, new_f_next;
    logic [7:0]          age_new_reg, age_new_next;
    pfm_pkg::frame_ent_t fr_hold_reg, fr_hold_next;
    pfm_pkg::rsp_t       res_reg, res_next;
    pfm_pkg::rsp_t       out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [NS-1:0]       at_floor;
    logic                better;
    pfm_pkg::rank_t      cand_rank;
    logic [FW-1:0]       take_f;
    logic [7:0]          ag_age;

    pfm_rank u_rank
    (
        .cand   (cand_rank),
        .best   (best_reg),
        .better (better)
    );

    assign cand_rank = '{valid: 1'b1, age: fr_rd.age, count: fr_rd.count};
    assign take_f    = FW'(hint_reg + idx_reg[FW-1:0]);
    assign ag_age    = {pg_rd.referenced, pg_rd.age[7:1]};

    // active owners at or below their floor are protected from global eviction
    always_comb
    begin
        for (int p = 0; p < NS; p++)
        begin
            at_floor[p] = active_reg[p] && (held_reg[p] <= pfloor_reg[p]);
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        floor_cfg_next = floor_cfg_reg;
        used_next      = used_reg;
        tbl_next       = tbl_reg;
        free_next      = free_reg;
        hint_next      = hint_reg;
        active_next    = active_reg;
        has_tbl_next   = has_tbl_reg;
        held_next      = held_reg;
        pfloor_next    = pfloor_reg;
        cap_next       = cap_reg;
        tframe_next    = tframe_reg;
        best_next      = best_reg;
        best_f_next    = best_f_reg;
        cand_next      = cand_reg;
        new_f_next     = new_f_reg;
        age_new_next   = age_new_reg;
        fr_hold_next   = fr_hold_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        fr_raddr       = '0;
        pg_raddr       = '0;
        fr_we          = 1'b0;
        fr_waddr       = '0;
        fr_wdata       = '0;
        pg_we          = 1'b0;
        pg_waddr       = '0;
        pg_wdata       = '0;

        if (cfg_we)
            floor_cfg_next = cfg_data;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next   = req.data;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                res_next  = '0;
                best_next = '0;
                idx_next  = '0;
                slot_next = '0;
                case (req_reg.action)
                    pfm_pkg::ACT_TICK:
                    begin
                        res_next.status = pfm_pkg::ST_DONE;
                        state_next      = S_AG_RD;
                    end
                    pfm_pkg::ACT_FAULT:
                    begin
                        if (!has_tbl_reg[req_reg.pid])
                        begin
                            res_next.status = pfm_pkg::ST_NO_TABLE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            pg_raddr   = {req_reg.pid, req_reg.vpn};
                            state_next = S_F_CHK;
                        end
                    end
                    pfm_pkg::ACT_MARK:
                    begin
                        if (!has_tbl_reg[req_reg.pid])
                        begin
                            res_next.status = pfm_pkg::ST_NO_TABLE;
                            state_next      = S_FIN;
                        end
                        else if (!used_reg[req_reg.frame_number])
                        begin
                            res_next.status = pfm_pkg::ST_IGNORED;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            fr_raddr   = req_reg.frame_number;
                            state_next = S_MK_FR;
                        end
                    end
                    default:
                    begin
                        if (has_tbl_reg[req_reg.pid])
                            state_next = S_ST_LIM;
                        else
                            state_next = S_TAKE;
                    end
                endcase
            end

            // ---- fault ----
            S_F_CHK:
            begin
                if (pg_rd.present)
                begin
                    res_next.status = pfm_pkg::ST_RESIDENT;
                    res_next.frame  = pg_rd.frame;
                    state_next      = S_FIN;
                end
                else if (cap_reg[req_reg.pid] != '0 &&
                         held_reg[req_reg.pid] >= cap_reg[req_reg.pid])
                    state_next = S_CAP_RD;
                else
                    state_next = S_TAKE;
            end

            // own-page victim search for a slot at its cap
            S_CAP_RD:
            begin
                if (idx_reg == IW'(NP))
                    state_next = S_CAP_END;
                else
                begin
                    pg_raddr   = {req_reg.pid, idx_reg[VW-1:0]};
                    state_next = S_CAP_PG;
                end
            end

            S_CAP_PG:
            begin
                if (pg_rd.present && idx_reg[VW-1:0] != req_reg.vpn &&
                    !tbl_reg[pg_rd.frame])
                begin
                    fr_raddr   = pg_rd.frame;
                    cand_next  = pg_rd.frame;
                    state_next = S_CAP_FR;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_CAP_RD;
                end
            end

            S_CAP_FR:
            begin
                if (better)
                begin
                    best_next   = cand_rank;
                    best_f_next = cand_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_CAP_RD;
            end

            S_CAP_END:
            begin
                if (best_reg.valid)
                    state_next = S_RC_RD;
                else
                begin
                    res_next.status = pfm_pkg::ST_NO_FRAME;
                    state_next      = S_FIN;
                end
            end

            // ---- reclaim best_f ----
            S_RC_RD:
            begin
                fr_raddr   = best_f_reg;
                state_next = S_RC_FR;
            end

            S_RC_FR:
            begin
                res_next.evicted       = 1'b1;
                res_next.evicted_frame = best_f_reg;
                res_next.evicted_pid   = fr_rd.owner;
                res_next.evicted_vpn   = fr_rd.page;
                res_next.writeback     = 1'b0;
                fr_hold_next           = fr_rd;
                if (active_reg[fr_rd.owner] && has_tbl_reg[fr_rd.owner])
                begin
                    pg_raddr   = {fr_rd.owner, fr_rd.page};
                    state_next = S_RC_PG;
                end
                else
                    state_next = S_RC_FREE;
            end

            S_RC_PG:
            begin
                if (pg_rd.present && pg_rd.frame == best_f_reg)
                begin
                    res_next.writeback = pg_rd.dirty;
                    pg_we    = 1'b1;
                    pg_waddr = {fr_hold_reg.owner, fr_hold_reg.page};
                    pg_wdata = '0;
                    if (held_reg[fr_hold_reg.owner] != '0)
                        held_next[fr_hold_reg.owner] = held_reg[fr_hold_reg.owner] - 1'b1;
                end
                state_next = S_RC_FREE;
            end

            S_RC_FREE:
            begin
                used_next[best_f_reg] = 1'b0;
                tbl_next[best_f_reg]  = 1'b0;
                free_next             = free_reg + 1'b1;
                idx_next              = '0;
                state_next            = S_TAKE;
            end

            // ---- rotating free-frame search ----
            S_TAKE:
            begin
                if (free_reg == '0)
                begin
                    if (req_reg.action == pfm_pkg::ACT_START || res_reg.evicted)
                    begin
                        res_next.status = pfm_pkg::ST_NO_FRAME;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        best_next  = '0;
                        idx_next   = '0;
                        state_next = S_GV_RD;
                    end
                end
                else if (!used_reg[take_f])
                begin
                    used_next[take_f] = 1'b1;
                    free_next         = free_reg - 1'b1;
                    hint_next         = take_f + 1'b1;
                    new_f_next        = take_f;
                    idx_next          = '0;
                    if (req_reg.action == pfm_pkg::ACT_START)
                    begin
                        tbl_next[take_f]            = 1'b1;
                        has_tbl_next[req_reg.pid]   = 1'b1;
                        tframe_next[req_reg.pid]    = take_f;
                        // table frame entry: owner is the slot, page 0
                        fr_we    = 1'b1;
                        fr_waddr = take_f;
                        fr_wdata = '{owner: req_reg.pid, page: '0, age: '0, count: '0};
                        state_next                  = S_ST_CLR;
                    end
                    else
                    begin
                        tbl_next[take_f] = 1'b0;
                        state_next       = S_F_FIN;
                    end
                end
                else
                    idx_next = idx_reg + 1'b1;
            end

            // ---- global victim search ----
            S_GV_RD:
            begin
                if (idx_reg == IW'(NF))
                begin
                    if (best_reg.valid)
                        state_next = S_RC_RD;
                    else
                    begin
                        res_next.status = pfm_pkg::ST_NO_FRAME;
                        state_next      = S_FIN;
                    end
                end
                else if (!used_reg[idx_reg[FW-1:0]] || tbl_reg[idx_reg[FW-1:0]])
                    idx_next = idx_reg + 1'b1;
                else
                begin
                    fr_raddr   = idx_reg[FW-1:0];
                    state_next = S_GV_FR;
                end
            end

            S_GV_FR:
            begin
                if (!at_floor[fr_rd.owner] && better)
                begin
                    best_next   = cand_rank;
                    best_f_next = idx_reg[FW-1:0];
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_GV_RD;
            end

            S_F_FIN:
            begin
                pg_we    = 1'b1;
                pg_waddr = {req_reg.pid, req_reg.vpn};
                pg_wdata = '{present: 1'b1, frame: new_f_reg, dirty: 1'b0,
                             referenced: 1'b1, age: pfm_pkg::AGE_FRESH};
                fr_we    = 1'b1;
                fr_waddr = new_f_reg;
                fr_wdata = '{owner: req_reg.pid, page: req_reg.vpn,
                             age: pfm_pkg::AGE_FRESH, count: 32'd1};
                held_next[req_reg.pid] = held_reg[req_reg.pid] + 1'b1;
                res_next.status = pfm_pkg::ST_DONE;
                res_next.frame  = new_f_reg;
                state_next      = S_FIN;
            end

            // ---- write mark ----
            S_MK_FR:
            begin
                if (fr_rd.owner != req_reg.pid)
                begin
                    res_next.status = pfm_pkg::ST_IGNORED;
                    state_next      = S_FIN;
                end
                else
                begin
                    fr_hold_next = fr_rd;
                    pg_raddr     = {req_reg.pid, fr_rd.page};
                    state_next   = S_MK_PG;
                end
            end

            S_MK_PG:
            begin
                if (!pg_rd.present || pg_rd.frame != req_reg.frame_number)
                    res_next.status = pfm_pkg::ST_IGNORED;
                else
                begin
                    pg_we    = 1'b1;
                    pg_waddr = {req_reg.pid, fr_hold_reg.page};
                    pg_wdata = pg_rd;
                    pg_wdata.dirty      = 1'b1;
                    pg_wdata.referenced = 1'b1;
                    fr_we    = 1'b1;
                    fr_waddr = req_reg.frame_number;
                    fr_wdata = fr_hold_reg;
                    if (fr_hold_reg.count != '1)
                        fr_wdata.count = fr_hold_reg.count + 1'b1;
                    res_next.status = pfm_pkg::ST_DONE;
                    res_next.frame  = req_reg.frame_number;
                end
                state_next = S_FIN;
            end

            // ---- process start ----
            S_ST_CLR:
            begin
                if (idx_reg == IW'(NP))
                    state_next = S_ST_LIM;
                else
                begin
                    pg_we    = 1'b1;
                    pg_waddr = {req_reg.pid, idx_reg[VW-1:0]};
                    pg_wdata = '0;
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_ST_LIM:
            begin
                pfloor_next[req_reg.pid] = (req_reg.floor_request < floor_cfg_reg) ?
                                           floor_cfg_reg : req_reg.floor_request;
                cap_next[req_reg.pid] = (req_reg.cap_request == '0 ||
                                         req_reg.cap_request > LW'(NP)) ?
                                        LW'(NP) : req_reg.cap_request;
                active_next[req_reg.pid] = 1'b1;
                res_next.status = pfm_pkg::ST_DONE;
                res_next.frame  = tframe_reg[req_reg.pid];
                state_next      = S_FIN;
            end

            // ---- aging tick ----
            S_AG_RD:
            begin
                if (idx_reg == IW'(NP))
                begin
                    idx_next = '0;
                    if (slot_reg == PW'(NS - 1))
                        state_next = S_FIN;
                    else
                        slot_next = slot_reg + 1'b1;
                end
                else if (!(active_reg[slot_reg] && has_tbl_reg[slot_reg]))
                    idx_next = IW'(NP);
                else
                begin
                    pg_raddr   = {slot_reg, idx_reg[VW-1:0]};
                    state_next = S_AG_PG;
                end
            end

            S_AG_PG:
            begin
                state_next = S_AG_RD;
                idx_next   = idx_reg + 1'b1;
                if (pg_rd.present)
                begin
                    pg_we    = 1'b1;
                    pg_waddr = {slot_reg, idx_reg[VW-1:0]};
                    pg_wdata = pg_rd;
                    pg_wdata.age        = ag_age;
                    pg_wdata.referenced = 1'b0;
                    if (used_reg[pg_rd.frame])
                    begin
                        fr_raddr     = pg_rd.frame;
                        cand_next    = pg_rd.frame;
                        age_new_next = ag_age;
                        idx_next     = idx_reg;
                        state_next   = S_AG_FR;
                    end
                end
            end

            S_AG_FR:
            begin
                fr_we    = 1'b1;
                fr_waddr = cand_reg;
                fr_wdata = fr_rd;
                fr_wdata.age   = age_new_reg;
                fr_wdata.count = fr_rd.count >> 1;
                idx_next   = idx_reg + 1'b1;
                state_next = S_AG_RD;
            end

            // ---- hand the response to the output register ----
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            floor_cfg_reg <= 9'd3;
            used_reg      <= '0;
            tbl_reg       <= '0;
            free_reg      <= IW'(NF);
            hint_reg      <= '0;
            active_reg    <= '0;
            has_tbl_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NS; p++)
            begin
                held_reg[p]   <= '0;
                pfloor_reg[p] <= '0;
                cap_reg[p]    <= '0;
                tframe_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            floor_cfg_reg <= floor_cfg_next;
            used_reg      <= used_next;
            tbl_reg       <= tbl_next;
            free_reg      <= free_next;
            hint_reg      <= hint_next;
            active_reg    <= active_next;
            has_tbl_reg   <= has_tbl_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            pfloor_reg    <= pfloor_next;
            cap_reg       <= cap_next;
            tframe_reg    <= tframe_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        best_reg    <= best_next;
        best_f_reg  <= best_f_next;
        cand_reg    <= cand_next;
        new_f_reg   <= new_f_next;
        age_new_reg <= age_new_next;
        fr_hold_reg <= fr_hold_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

endmodule

[hw/rtl/pfm_rank.sv]
// Module: victim ranking compare, lower age then lower count wins.
module pfm_rank
(
    input  pfm_pkg::rank_t cand,
    input  pfm_pkg::rank_t best,
    output logic           better
);

    always_comb
    begin
        if (!best.valid)
            better = 1'b1;
        else if (cand.age < best.age)
            better = 1'b1;
        else
            better = (cand.age == best.age) && (cand.count < best.count);
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench: self-checking stimulus and frame-table predictor for the paging frame manager.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_data;

    pfm_stream_if #(.T(pfm_pkg::req_t)) req_if ();
    pfm_stream_if #(.T(pfm_pkg::rsp_t)) rsp_if ();

    paging_frame_manager_lfu_aging DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_if),
        .rsp      (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: frame table, page tables, per-slot limits
    // ------------------------------------------------------------------
    localparam int NFR = pfm_pkg::FRAME_COUNT;
    localparam int NPG = pfm_pkg::PAGES_PER_PROCESS;
    localparam int NSL = pfm_pkg::PROCESS_SLOTS;

    bit          fr_used   [NFR];
    bit          fr_table  [NFR];
    int unsigned fr_owner  [NFR];
    int unsigned fr_page   [NFR];
    int unsigned fr_age    [NFR];
    int unsigned fr_cnt    [NFR];
    int unsigned free_cnt;
    int unsigned hint;

    localparam int PAGE_ENTRIES = NSL * NPG;
    bit          pg_present [PAGE_ENTRIES];
    int unsigned pg_frame   [PAGE_ENTRIES];
    bit          pg_dirty   [PAGE_ENTRIES];
    bit          pg_ref     [PAGE_ENTRIES];
    int unsigned pg_age     [PAGE_ENTRIES];

    bit          pr_active [NSL];
    bit          pr_table  [NSL];
    int unsigned pr_held   [NSL];
    int unsigned pr_floor  [NSL];
    int unsigned pr_cap    [NSL];
    int unsigned pr_tframe [NSL];

    int unsigned floor_min;     // shadow of the min resident floor register

    // eviction record of the request being predicted
    bit          ev_any;
    int unsigned ev_frame;
    int unsigned ev_pid;
    int unsigned ev_vpn;
    bit          ev_wb;
    int unsigned out_frame;

    pfm_pkg::rsp_t expected_rsps[$];
    int            mismatches = 0;

    // run control shared between the sender and the response side
    bit idle_on;        // random bursts of idling allowed
    bit long_hold;      // receiver asked to stall for a long stretch

    // Rotating free-frame search from the allocation hint; -1 when full.
    function automatic int grab_free_frame(int unsigned owner, int unsigned vpn, bit is_table);
        int unsigned f;
        if (free_cnt == 0)
            return -1;
        for (int s = 0; s < NFR; s++)
        begin
            f = (hint + s) % NFR;
            if (fr_used[f])
                continue;
            fr_used[f]  = 1'b1;
            fr_table[f] = is_table;
            fr_owner[f] = owner;
            fr_page[f]  = vpn;
            fr_age[f]   = 0;
            fr_cnt[f]   = 0;
            free_cnt--;
            hint = (f + 1) % NFR;
            return f;
        end
        return -1;
    endfunction

    function automatic void reclaim_frame(int unsigned f);
        int unsigned own;
        int unsigned pg;
        int unsigned i;
        own      = fr_owner[f];
        pg       = fr_page[f];
        ev_any   = 1'b1;
        ev_frame = f;
        ev_pid   = own;
        ev_vpn   = pg;
        ev_wb    = 1'b0;
        if (pr_active[own] && pr_table[own])
        begin
            i = own * NPG + pg;
            if (pg_present[i] && pg_frame[i] == f)
            begin
                ev_wb         = pg_dirty[i];
                pg_present[i] = 1'b0;
                pg_frame[i]   = 0;
                pg_dirty[i]   = 1'b0;
                pg_ref[i]     = 1'b0;
                pg_age[i]     = 0;
                if (pr_held[own] != 0)
                    pr_held[own]--;
            end
        end
        fr_used[f]  = 1'b0;
        fr_table[f] = 1'b0;
        fr_owner[f] = 0;
        fr_page[f]  = 0;
        fr_age[f]   = 0;
        fr_cnt[f]   = 0;
        free_cnt++;
    endfunction

    // Victim ranking: lower age wins, then lower count; ties keep the earlier index.
    function automatic bit ranks_lower(int f, int best);
        if (best < 0)
            return 1'b1;
        if (fr_age[f] < fr_age[best])
            return 1'b1;
        return fr_age[f] == fr_age[best] && fr_cnt[f] < fr_cnt[best];
    endfunction

    function automatic logic [2:0] page_fault(int unsigned pid, int unsigned vpn);
        int unsigned base;
        int unsigned i;
        int unsigned c;
        int          best;
        int          f;
        base = pid * NPG;
        i    = base + vpn;
        if (!pr_table[pid])
            return pfm_pkg::ST_NO_TABLE;
        if (pg_present[i])
        begin
            out_frame = pg_frame[i];
            return pfm_pkg::ST_RESIDENT;
        end
        // at its cap: the slot gives up one of its own pages first
        if (pr_cap[pid] != 0 && pr_held[pid] >= pr_cap[pid])
        begin
            best = -1;
            for (int v = 0; v < NPG; v++)
            begin
                if (!pg_present[base + v] || v == vpn)
                    continue;
                c = pg_frame[base + v];
                if (fr_table[c])
                    continue;
                if (ranks_lower(c, best))
                    best = c;
            end
            if (best < 0)
                return pfm_pkg::ST_NO_FRAME;
            reclaim_frame(best);
        end
        f = grab_free_frame(pid, vpn, 1'b0);
        if (f < 0)
        begin
            if (ev_any)
                return pfm_pkg::ST_NO_FRAME;
            // global victim: skip page tables and active owners at or below their floor
            best = -1;
            for (int g = 0; g < NFR; g++)
            begin
                if (!fr_used[g] || fr_table[g])
                    continue;
                if (pr_active[fr_owner[g]] && pr_held[fr_owner[g]] <= pr_floor[fr_owner[g]])
                    continue;
                if (ranks_lower(g, best))
                    best = g;
            end
            if (best < 0)
                return pfm_pkg::ST_NO_FRAME;
            reclaim_frame(best);
            f = grab_free_frame(pid, vpn, 1'b0);
            if (f < 0)
                return pfm_pkg::ST_NO_FRAME;
        end
        pg_present[i] = 1'b1;
        pg_frame[i]   = f;
        pg_dirty[i]   = 1'b0;
        pg_ref[i]     = 1'b1;
        pg_age[i]     = 32'(pfm_pkg::AGE_FRESH);
        fr_age[f]     = 32'(pfm_pkg::AGE_FRESH);
        fr_cnt[f]     = 1;
        pr_held[pid]++;
        out_frame = f;
        return pfm_pkg::ST_DONE;
    endfunction

    function automatic logic [2:0] write_mark(int unsigned pid, int unsigned f);
        int unsigned i;
        if (!pr_table[pid])
            return pfm_pkg::ST_NO_TABLE;
        if (!fr_used[f] || fr_owner[f] != pid)
            return pfm_pkg::ST_IGNORED;
        i = pid * NPG + fr_page[f];
        if (!pg_present[i] || pg_frame[i] != f)
            return pfm_pkg::ST_IGNORED;
        pg_dirty[i] = 1'b1;
        pg_ref[i]   = 1'b1;
        if (fr_cnt[f] != 32'hFFFF_FFFF)
            fr_cnt[f]++;
        out_frame = f;
        return pfm_pkg::ST_DONE;
    endfunction

    function automatic logic [2:0] process_start(int unsigned pid, int unsigned fl,
                                                 int unsigned cp);
        int f;
        if (!pr_table[pid])
        begin
            f = grab_free_frame(pid, 0, 1'b1);
            if (f < 0)
                return pfm_pkg::ST_NO_FRAME;
            pr_table[pid]  = 1'b1;
            pr_tframe[pid] = f;
            for (int v = 0; v < NPG; v++)
            begin
                pg_present[pid * NPG + v] = 1'b0;
                pg_frame[pid * NPG + v]   = 0;
                pg_dirty[pid * NPG + v]   = 1'b0;
                pg_ref[pid * NPG + v]     = 1'b0;
                pg_age[pid * NPG + v]     = 0;
            end
        end
        pr_floor[pid]  = (fl < floor_min) ? floor_min : fl;
        pr_cap[pid]    = (cp == 0 || cp > NPG) ? NPG : cp;
        pr_active[pid] = 1'b1;
        out_frame      = pr_tframe[pid];
        return pfm_pkg::ST_DONE;
    endfunction

    function automatic void aging_tick();
        int unsigned i;
        int unsigned f;
        for (int p = 0; p < NSL; p++)
        begin
            if (!pr_active[p] || !pr_table[p])
                continue;
            for (int v = 0; v < NPG; v++)
            begin
                i = p * NPG + v;
                if (!pg_present[i])
                    continue;
                pg_age[i] = ((pg_age[i] >> 1) | (pg_ref[i] ? 32'h80 : 32'h0)) & 32'hFF;
                pg_ref[i] = 1'b0;
                f = pg_frame[i];
                if (fr_used[f])
                begin
                    fr_age[f] = pg_age[i];
                    fr_cnt[f] = fr_cnt[f] >> 1;
                end
            end
        end
    endfunction

    // Advances the predictor by one request and returns the response it implies.
    function automatic pfm_pkg::rsp_t predict_response(pfm_pkg::req_t r);
        pfm_pkg::rsp_t res;
        logic [2:0]    st;
        ev_any    = 1'b0;
        ev_frame  = 0;
        ev_pid    = 0;
        ev_vpn    = 0;
        ev_wb     = 1'b0;
        out_frame = 0;
        case (r.action)
            pfm_pkg::ACT_TICK:
            begin
                aging_tick();
                st = pfm_pkg::ST_DONE;
            end
            pfm_pkg::ACT_FAULT: st = page_fault(32'(r.pid), 32'(r.vpn));
            pfm_pkg::ACT_MARK:  st = write_mark(32'(r.pid), 32'(r.frame_number));
            default:   st = process_start(32'(r.pid), 32'(r.floor_request),
                                          32'(r.cap_request));
        endcase
        res.status        = st;
        res.frame         = out_frame[7:0];
        res.evicted       = ev_any;
        res.evicted_frame = ev_any ? ev_frame[7:0] : 8'd0;
        res.evicted_pid   = ev_any ? ev_pid[2:0] : 3'd0;
        res.evicted_vpn   = ev_any ? ev_vpn[7:0] : 8'd0;
        res.writeback     = ev_any && ev_wb;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Response side: ready with random stalls and one long hold-off
    // ------------------------------------------------------------------
    int stall_left;
    bit hold_done;

    initial
    begin
        rsp_if.ready <= 1'b0;
        stall_left = 0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (long_hold && !hold_done)
            begin
                // long hold-off: the response register fills, then request ready drops
                hold_done  = 1'b1;
                stall_left = 400;
                rsp_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    function automatic void field_check(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s expected %0d got %0d", $realtime, name, want, got);
        end
    endfunction

    // Checker: each accepted response against the oldest expectation.
    always @(posedge clk)
    begin
        pfm_pkg::rsp_t want;
        pfm_pkg::rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.data;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response at %0t: status %0d frame %0d",
                             $realtime, got.status, got.frame);
            end
            else
            begin
                want = expected_rsps.pop_front();
                field_check("status",        32'(want.status),        32'(got.status));
                field_check("frame",         32'(want.frame),         32'(got.frame));
                field_check("evicted",       32'(want.evicted),       32'(got.evicted));
                field_check("evicted_frame", 32'(want.evicted_frame), 32'(got.evicted_frame));
                field_check("evicted_pid",   32'(want.evicted_pid),   32'(got.evicted_pid));
                field_check("evicted_vpn",   32'(want.evicted_vpn),   32'(got.evicted_vpn));
                field_check("writeback",     32'(want.writeback),     32'(got.writeback));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    typedef struct {
        pfm_pkg::req_t r;
        bit            typed;    // expected response written into the row
        pfm_pkg::rsp_t want;
    } stim_row_t;

    stim_row_t directed_rows[$];

    function automatic pfm_pkg::req_t make_req(logic [1:0] act, int unsigned pid,
                                               int unsigned vpn, int unsigned fnum,
                                               int unsigned fl, int unsigned cp);
        pfm_pkg::req_t r;
        r.action        = act;
        r.pid           = pid[2:0];
        r.vpn           = vpn[7:0];
        r.frame_number  = fnum[7:0];
        r.floor_request = fl[8:0];
        r.cap_request   = cp[8:0];
        return r;
    endfunction

    function automatic pfm_pkg::rsp_t make_rsp(logic [2:0] st, int unsigned fr);
        pfm_pkg::rsp_t s;
        s        = '0;
        s.status = st;
        s.frame  = fr[7:0];
        return s;
    endfunction

    function automatic void add_row(pfm_pkg::req_t r, bit typed, pfm_pkg::rsp_t want);
        stim_row_t row;
        row.r     = r;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Random request: every field random, then shaped toward useful actions.
    function automatic pfm_pkg::req_t random_request();
        pfm_pkg::req_t r;
        logic [63:0]   raw;
        int unsigned   k;
        int unsigned   f;
        raw = {$urandom, $urandom};
        r   = raw[$bits(pfm_pkg::req_t)-1:0];
        k   = $urandom_range(0, 99);
        if (k < 5)
        begin
            r.action = pfm_pkg::ACT_TICK;
        end
        else if (k < 15)
        begin
            r.action = pfm_pkg::ACT_START;
            if ($urandom_range(0, 9) < 7)
                r.floor_request = 9'($urandom_range(0, 6));
            case ($urandom_range(0, 2))
                0:       r.cap_request = 9'd0;
                1:       r.cap_request = 9'($urandom_range(1, 6));
                default: r.cap_request = 9'($urandom_range(0, 511));
            endcase
        end
        else if (k < 27)
        begin
            r.action = pfm_pkg::ACT_MARK;
            // mostly hit a frame that is really in use by its owner
            if (free_cnt < NFR && $urandom_range(0, 4) != 0)
            begin
                f = $urandom_range(0, NFR - 1);
                while (!fr_used[f])
                    f = (f + 1) % NFR;
                r.pid          = 3'(fr_owner[f]);
                r.frame_number = 8'(f);
            end
        end
        else
        begin
            r.action = pfm_pkg::ACT_FAULT;
            if ($urandom_range(0, 9) < 3)
                r.vpn = 8'($urandom_range(0, 7));
        end
        return r;
    endfunction

    task automatic issue(pfm_pkg::req_t r, bit typed, pfm_pkg::rsp_t want);
        pfm_pkg::rsp_t p;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        p = predict_response(r);
        expected_rsps.push_back(typed ? want : p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Sender pause: all responses back, then a short settle.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Register write while the block is idle.
    task automatic write_floor(int unsigned v);
        cfg_we   <= 1'b1;
        cfg_data <= v[8:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        floor_min = v;
        @(posedge clk);
    endtask

    task automatic random_phase(int n, int hold_at);
        pfm_pkg::rsp_t none;
        none = '0;
        for (int k = 0; k < n; k++)
        begin
            if (k == hold_at)
                long_hold = 1'b1;
            issue(random_request(), 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        pfm_pkg::rsp_t none;
        none = '0;

        rst_n        = 1'b0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        idle_on   = 1'b1;
        long_hold = 1'b0;

        // predictor reset state
        floor_min = 3;
        free_cnt  = NFR;
        hint      = 0;
        foreach (fr_used[f])
        begin
            fr_used[f]  = 1'b0;
            fr_table[f] = 1'b0;
            fr_owner[f] = 0;
            fr_page[f]  = 0;
            fr_age[f]   = 0;
            fr_cnt[f]   = 0;
        end
        foreach (pg_present[i])
        begin
            pg_present[i] = 1'b0;
            pg_frame[i]   = 0;
            pg_dirty[i]   = 1'b0;
            pg_ref[i]     = 1'b0;
            pg_age[i]     = 0;
        end
        foreach (pr_active[p])
        begin
            pr_active[p] = 1'b0;
            pr_table[p]  = 1'b0;
            pr_held[p]   = 0;
            pr_floor[p]  = 0;
            pr_cap[p]    = 0;
            pr_tframe[p] = 0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Fresh block: frames come out of the hint in order 0, 1, 2 ...
        add_row(make_req(pfm_pkg::ACT_FAULT, 0, 5, 0, 0, 0), 1,
                make_rsp(pfm_pkg::ST_NO_TABLE, 0));
        add_row(make_req(pfm_pkg::ACT_MARK, 7, 0, 255, 0, 0), 1,
                make_rsp(pfm_pkg::ST_NO_TABLE, 0));
        add_row(make_req(pfm_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1,
                make_rsp(pfm_pkg::ST_DONE, 0));
        add_row(make_req(pfm_pkg::ACT_START, 0, 0, 0, 0, 2), 1,
                make_rsp(pfm_pkg::ST_DONE, 0));
        add_row(make_req(pfm_pkg::ACT_START, 7, 255, 255, 511, 511), 1,
                make_rsp(pfm_pkg::ST_DONE, 1));
        add_row(make_req(pfm_pkg::ACT_FAULT, 0, 0, 0, 0, 0), 1,
                make_rsp(pfm_pkg::ST_DONE, 2));
        add_row(make_req(pfm_pkg::ACT_FAULT, 0, 255, 0, 0, 0), 1,
                make_rsp(pfm_pkg::ST_DONE, 3));
        add_row(make_req(pfm_pkg::ACT_FAULT, 0, 0, 0, 0, 0), 1,
                make_rsp(pfm_pkg::ST_RESIDENT, 2));
        add_row(make_req(pfm_pkg::ACT_MARK, 0, 0, 3, 0, 0), 1,
                make_rsp(pfm_pkg::ST_DONE, 3));
        // frame owned by another slot, then a page-table frame: both ignored
        add_row(make_req(pfm_pkg::ACT_MARK, 0, 0, 1, 0, 0), 1,
                make_rsp(pfm_pkg::ST_IGNORED, 0));
        add_row(make_req(pfm_pkg::ACT_MARK, 7, 0, 1, 0, 0), 1,
                make_rsp(pfm_pkg::ST_IGNORED, 0));
        // cap of two reached: slot 0 evicts one of its own pages
        add_row(make_req(pfm_pkg::ACT_FAULT, 0, 128, 0, 0, 0),   0, none);
        add_row(make_req(pfm_pkg::ACT_TICK, 0, 0, 0, 0, 0),      0, none);
        add_row(make_req(pfm_pkg::ACT_MARK, 0, 0, 3, 0, 0),      0, none);
        add_row(make_req(pfm_pkg::ACT_FAULT, 0, 7, 0, 0, 0),     0, none);   // clean victim
        add_row(make_req(pfm_pkg::ACT_START, 0, 0, 0, 5, 0),     0, none);   // keeps table
        add_row(make_req(pfm_pkg::ACT_START, 3, 0, 0, 256, 1),   0, none);
        add_row(make_req(pfm_pkg::ACT_FAULT, 3, 9, 0, 0, 0),     0, none);
        add_row(make_req(pfm_pkg::ACT_FAULT, 3, 10, 0, 0, 0),    0, none);
        add_row(make_req(pfm_pkg::ACT_MARK, 3, 0, 255, 0, 0),    0, none);
        add_row(make_req(pfm_pkg::ACT_FAULT, 7, 255, 0, 0, 0),   0, none);
        add_row(make_req(pfm_pkg::ACT_TICK, 0, 0, 0, 0, 0),      0, none);
        foreach (directed_rows[k])
            issue(directed_rows[k].r, directed_rows[k].typed, directed_rows[k].want);
        drain();

        // Random phases across floor settings.
        write_floor(0);
        random_phase(90, 40);
        drain();
        write_floor(256);
        random_phase(90, -1);
        drain();
        write_floor($urandom_range(1, 255));
        idle_on = 1'b0;     // closing stretch runs without idling
        random_phase(90, -1);
        drain();

        if (mismatches == 0)
            $display("** paging_frame_manager_lfu_aging: PASSED **");
        else
            $display("** paging_frame_manager_lfu_aging: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("** paging_frame_manager_lfu_aging: FAILED **");
        $finish;
    end

endmodule
